// ----- src/pssd_pkg.sv -----
// ----------------------------------------------------------------------------
// pssd_pkg
// shared constants and types for the patch ssd match select block
// ----------------------------------------------------------------------------
package pssd_pkg;

  localparam int MaxCand   = 64;
  localparam int IdxW      = $clog2(MaxCand);
  localparam int CntW      = IdxW + 1;
  localparam int SampleW   = 8;
  localparam int CoordW    = 12;
  localparam int DistW     = 32;
  localparam int TotalW    = 10;
  localparam int FppW      = 4;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 32;
  localparam int SqW       = 2 * SampleW;

  localparam logic [CfgIdxW-1:0] CFG_FPP    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MINP   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_THRESH = 2'd2;

  localparam logic [FppW-1:0]   FppReset  = 4'd5;
  localparam logic [TotalW-1:0] MinReset  = 10'd83;
  localparam logic [TotalW-1:0] TotalMax  = 10'd1023;

  typedef struct packed {
    logic [SampleW-1:0] ref_red;
    logic [SampleW-1:0] ref_green;
    logic [SampleW-1:0] ref_blue;
    logic [SampleW-1:0] cand_red;
    logic [SampleW-1:0] cand_green;
    logic [SampleW-1:0] cand_blue;
    logic [CoordW-1:0]  cand_col;
    logic [CoordW-1:0]  cand_row;
    logic               end_of_candidate;
    logic               end_of_window;
  } pix_t;

  typedef struct packed {
    logic [CoordW-1:0] match_col;
    logic [CoordW-1:0] match_row;
    logic [DistW-1:0]  match_distance;
    logic [TotalW-1:0] patch_total;
    logic              last_match;
  } match_t;

  // one finished candidate from the front to the back
  typedef struct packed {
    logic [DistW-1:0]  distance;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic              eow;
    logic              keep;
  } cand_t;

  function automatic logic [SqW-1:0] sq_diff(input logic [SampleW-1:0] a,
                                             input logic [SampleW-1:0] b);
    logic [SampleW-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SqW'(d) * SqW'(d);
  endfunction

endpackage

// ----- src/pssd_if.sv -----
// ----------------------------------------------------------------------------
// pssd_pix_if / pssd_match_if
// valid/ready channels for pixel pair words and match words
// ----------------------------------------------------------------------------
interface pssd_pix_if import pssd_pkg::*; ();
  logic valid;
  logic ready;
  pix_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pssd_match_if import pssd_pkg::*; ();
  logic   valid;
  logic   ready;
  match_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/pssd_front.sv -----
// ----------------------------------------------------------------------------
// pssd_front
// accumulates ssd per candidate, emits candidate records into a fifo
// ----------------------------------------------------------------------------
module pssd_front import pssd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  pix_t        in_data_i,
  output logic        rec_valid_o,
  input  logic        rec_ready_i,
  output cand_t       rec_o
);

  logic [DistW-1:0] acc_q, acc_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [SqW-1:0]   sq_r_q, sq_g_q, sq_b_q;
  pix_t             p_q;
  logic             s1_q;
  logic             rec_valid_q;
  cand_t            rec_q;
  logic             adv;
  logic [DistW+1:0] sum;
  logic [DistW-1:0] acc_sat;
  logic             close;

  // stage 1 registers the squares, stage 2 accumulates
  assign adv        = !rec_valid_q || rec_ready_i;
  assign in_ready_o = adv;
  assign sum = {2'b0, acc_q} + {{(DistW+2-SqW){1'b0}}, sq_r_q}
             + {{(DistW+2-SqW){1'b0}}, sq_g_q} + {{(DistW+2-SqW){1'b0}}, sq_b_q};
  assign acc_sat = (sum[DistW+1:DistW] != 2'b0) ? '1 : sum[DistW-1:0];
  assign close   = p_q.end_of_candidate || p_q.end_of_window;

  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (adv && s1_q) begin
      acc_d = close ? '0 : acc_sat;
      if (close && cnt_q < CntW'(MaxCand)) cnt_d = cnt_q + 1'b1;
      if (p_q.end_of_window) cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      cnt_q       <= '0;
      s1_q        <= 1'b0;
      rec_valid_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      if (adv) begin
        s1_q        <= in_valid_i;
        rec_valid_q <= s1_q && close;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_q    <= in_data_i;
      sq_r_q <= sq_diff(in_data_i.ref_red, in_data_i.cand_red);
      sq_g_q <= sq_diff(in_data_i.ref_green, in_data_i.cand_green);
      sq_b_q <= sq_diff(in_data_i.ref_blue, in_data_i.cand_blue);
      rec_q.distance <= acc_sat;
      rec_q.col  <= p_q.cand_col;
      rec_q.row  <= p_q.cand_row;
      rec_q.eow  <= p_q.end_of_window;
      rec_q.keep <= cnt_q < CntW'(MaxCand);
    end
  end

  assign rec_valid_o = rec_valid_q;
  assign rec_o       = rec_q;

endmodule

// ----- src/pssd_fifo.sv -----
// ----------------------------------------------------------------------------
// pssd_fifo
// short queue of candidate records between front and back
// ----------------------------------------------------------------------------
module pssd_fifo import pssd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_valid_i,
  output logic  wr_ready_o,
  input  cand_t wr_data_i,
  output logic  rd_valid_o,
  input  logic  rd_ready_i,
  output cand_t rd_data_o
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  cand_t           mem_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;
  logic            wr, rd;

  assign wr_ready_o = cnt_q != (PtrW+1)'(Depth);
  assign rd_valid_o = cnt_q != '0;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(wr) - (PtrW+1)'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule

// ----- src/pssd_back.sv -----
// ----------------------------------------------------------------------------
// pssd_back
// collects one window, insertion sorts it, then emits in distance order
// ----------------------------------------------------------------------------
module pssd_back import pssd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [FppW-1:0]   fpp_i,
  input  logic [TotalW-1:0] minp_i,
  input  logic [DistW-1:0]  thresh_i,
  input  logic              rec_valid_i,
  output logic              rec_ready_o,
  input  cand_t             rec_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output match_t            out_o
);

  localparam logic [2:0] ST_COLLECT = 3'd0;
  localparam logic [2:0] ST_SHIFT   = 3'd1;
  localparam logic [2:0] ST_READ    = 3'd2;
  localparam logic [2:0] ST_WAIT    = 3'd3;
  localparam logic [2:0] ST_EMIT    = 3'd4;

  localparam int EntW = DistW + 2 * CoordW;

  logic [EntW-1:0]   mem [MaxCand];
  logic [2:0]        st_q;
  logic [CntW-1:0]   n_q;      // stored entries
  logic [CntW-1:0]   j_q;      // insertion position / emit index
  logic [EntW-1:0]   new_q;    // entry being inserted
  logic [EntW-1:0]   rd_q;
  logic [TotalW-1:0] total_q;
  logic              eow_q;
  logic              out_valid_q;
  match_t            out_q;
  logic [TotalW:0]   tsum;
  logic [TotalW-1:0] tnext;
  logic              stop;

  // insertion: each incoming record walks down from the top, one entry
  // moved per read (ST_SHIFT) and compare (ST_READ) step, keeping arrival order
  assign rec_ready_o = (st_q == ST_COLLECT) && !out_valid_q;

  assign tsum  = {1'b0, total_q} + (TotalW+1)'(fpp_i);
  assign tnext = tsum[TotalW] ? TotalMax : tsum[TotalW-1:0];
  assign stop  = (tnext >= minp_i) && (rd_q[EntW-1 -: DistW] > thresh_i);

  always_ff @(posedge clk_i) begin
    if (st_q == ST_SHIFT) rd_q <= mem[j_q[IdxW-1:0] - 1'b1];
    else rd_q <= mem[j_q[IdxW-1:0]];
    if (st_q == ST_READ) begin
      if (j_q != '0 && rd_q[EntW-1 -: DistW] > new_q[EntW-1 -: DistW])
        mem[j_q[IdxW-1:0]] <= rd_q;
      else
        mem[j_q[IdxW-1:0]] <= new_q;
    end
    if (rec_valid_i && rec_ready_o) new_q <= {rec_i.distance, rec_i.col, rec_i.row};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_COLLECT;
      n_q         <= '0;
      j_q         <= '0;
      total_q     <= '0;
      eow_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (st_q == ST_EMIT && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (st_q)
        ST_COLLECT: begin
          if (rec_valid_i && rec_ready_o) begin
            eow_q <= rec_i.eow;
            if (rec_i.keep) begin
              j_q  <= n_q;
              n_q  <= n_q + 1'b1;
              st_q <= ST_SHIFT;
            end else if (rec_i.eow) begin
              j_q     <= '0;
              total_q <= '0;
              st_q    <= ST_WAIT;
            end
          end
        end
        ST_SHIFT: st_q <= ST_READ; // rd_q <= mem[j-1]
        ST_READ: begin
          if (j_q != '0 && rd_q[EntW-1 -: DistW] > new_q[EntW-1 -: DistW]) begin
            j_q  <= j_q - 1'b1;
            st_q <= ST_SHIFT;
          end else if (eow_q) begin
            j_q     <= '0;
            total_q <= '0;
            st_q    <= ST_WAIT;
          end else begin
            st_q <= ST_COLLECT;
          end
        end
        ST_WAIT: begin
          // mem read of entry j lands in rd_q
          if (j_q == n_q) begin
            n_q  <= '0;
            st_q <= ST_COLLECT;
          end else begin
            st_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.match_distance <= rd_q[EntW-1 -: DistW];
            out_q.match_col      <= rd_q[2*CoordW-1 -: CoordW];
            out_q.match_row      <= rd_q[CoordW-1:0];
            out_q.patch_total    <= tnext;
            out_q.last_match     <= stop || (j_q + 1'b1 == n_q);
            total_q              <= tnext;
            if (stop || (j_q + 1'b1 == n_q)) begin
              n_q  <= '0;
              st_q <= ST_COLLECT;
            end else begin
              j_q  <= j_q + 1'b1;
              st_q <= ST_WAIT;
            end
          end
        end
        default: st_q <= ST_COLLECT;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ----- src/patch_ssd_match_select_top.sv -----
// ----------------------------------------------------------------------------
// patch_ssd_match_select_top
// block matching with ssd distance, stable sort and threshold-limited emission
// ----------------------------------------------------------------------------
// The front takes one pixel pair word per cycle while its record output
// is not stalled, squares the three channel differences in one stage and
// adds them into a saturating 32-bit accumulator in the next; every
// candidate end leaves a record in a four-deep queue. The back stores the
// records of a window in a 64-entry memory, inserting each in sorted place
// as it arrives, one entry moved per read and compare step (one memory read
// port), while the front keeps accumulating until the queue fills. After
// the window end the back emits the match words in distance order. No
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module patch_ssd_match_select_top import pssd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  pssd_pix_if.sink            pix,
  pssd_match_if.source        match
);

  logic [FppW-1:0]   fpp_q;
  logic [TotalW-1:0] minp_q;
  logic [DistW-1:0]  thresh_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fpp_q    <= FppReset;
      minp_q   <= MinReset;
      thresh_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FPP:    fpp_q    <= cfg_data_i[FppW-1:0];
        CFG_MINP:   minp_q   <= cfg_data_i[TotalW-1:0];
        CFG_THRESH: thresh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic  f_valid, f_ready, b_valid, b_ready;
  cand_t f_rec, b_rec;

  pssd_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (pix.valid),
    .in_ready_o (pix.ready),
    .in_data_i  (pix.data),
    .rec_valid_o(f_valid),
    .rec_ready_i(f_ready),
    .rec_o      (f_rec)
  );

  pssd_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid),
    .wr_ready_o(f_ready),
    .wr_data_i (f_rec),
    .rd_valid_o(b_valid),
    .rd_ready_i(b_ready),
    .rd_data_o (b_rec)
  );

  pssd_back u_back (
    .clk_i, .rst_ni,
    .fpp_i      (fpp_q),
    .minp_i     (minp_q),
    .thresh_i   (thresh_q),
    .rec_valid_i(b_valid),
    .rec_ready_o(b_ready),
    .rec_i      (b_rec),
    .out_valid_o(match.valid),
    .out_ready_i(match.ready),
    .out_o      (match.data)
  );

  // a stalled match word keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match.valid && !match.ready |=> match.valid && $stable(match.data))
    else $error("match word changed while stalled");

  // patch total is never zero unless the per-candidate frame count is zero
  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match.valid |-> match.data.patch_total != '0 || fpp_q == '0)
    else $error("zero patch total");

endmodule

// ----- verif/tb_patch_ssd_match_select_top.sv -----
// ----------------------------------------------------------------------------
// tb_patch_ssd_match_select_top
// self-checking bench for the patch ssd match select block: pixel pair words
// go in under random idling and back-pressure, a local predictor works out
// the sorted, threshold-limited match words and each one is checked in order
// ----------------------------------------------------------------------------
module tb_patch_ssd_match_select_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pssd_pkg::*;

  // longest quiet stretch: full-window insertion sort plus the long hold-off
  localparam int WatchLimit  = 60000;
  // settle time before a register write, covers a full-window sort
  localparam int DrainCycles = 9000;
  localparam int HoldCycles  = 2000;
  localparam int PhaseItems  = 30;

  typedef struct {
    pix_t   p;
    bit     chk;
    match_t want;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  pssd_pix_if   pix_bus ();
  pssd_match_if match_bus ();

  patch_ssd_match_select_top u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix        (pix_bus.sink),
    .match      (match_bus.source)
  );

  // predictor copy of the registers and the candidate store
  logic [FppW-1:0]   fpp_q;
  logic [TotalW-1:0] minp_q;
  logic [DistW-1:0]  thresh_q;
  logic [DistW-1:0]  ssd_acc;
  logic [DistW-1:0]  ssd_tab [MaxCand];
  logic [CoordW-1:0] col_tab [MaxCand];
  logic [CoordW-1:0] row_tab [MaxCand];
  int                cand_cnt;

  match_t match_exp_q[$];

  int errors;
  int items_sent;
  int snd_idle_pct;
  int rcv_stall_pct;
  int hold_req;
  int hold_seen;
  int hold_cnt;
  int quiet_cnt;

  dir_row_t dir_tab[$];

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // every mismatch goes through here: one line, one count
  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
    errors++;
  endtask

  task automatic add_dir_row(input pix_t p, input bit chk, input match_t want);
    dir_row_t r;
    r.p    = p;
    r.chk  = chk;
    r.want = want;
    dir_tab.insert(dir_tab.size(), r);
  endtask

  function automatic logic [DistW-1:0] add_sat(input logic [DistW-1:0] a,
                                               input logic [DistW-1:0] b);
    logic [DistW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DistW] ? '1 : s[DistW-1:0];
  endfunction

  function automatic logic [DistW-1:0] chan_sq(input logic [SampleW-1:0] a,
                                               input logic [SampleW-1:0] b);
    logic [DistW-1:0] d;
    d = (a > b) ? DistW'(a - b) : DistW'(b - a);
    return d * d;
  endfunction

  // predictor: one pixel pair word in, zero or more match words queued
  task automatic predict_pair(input pix_t p);
    int                i;
    int                j;
    int                n;
    int unsigned       tot;
    logic [DistW-1:0]  d;
    logic [CoordW-1:0] c;
    logic [CoordW-1:0] r;
    bit                stop;
    match_t            m;
    ssd_acc = add_sat(ssd_acc, chan_sq(p.ref_red, p.cand_red));
    ssd_acc = add_sat(ssd_acc, chan_sq(p.ref_green, p.cand_green));
    ssd_acc = add_sat(ssd_acc, chan_sq(p.ref_blue, p.cand_blue));
    if (p.end_of_candidate || p.end_of_window) begin
      // a full store drops the candidate
      if (cand_cnt < MaxCand) begin
        ssd_tab[cand_cnt] = ssd_acc;
        col_tab[cand_cnt] = p.cand_col;
        row_tab[cand_cnt] = p.cand_row;
        cand_cnt++;
      end
      ssd_acc = '0;
    end
    if (!p.end_of_window) return;
    n = cand_cnt;
    // stable insertion sort, ascending distance
    for (i = 1; i < n; i++) begin
      d = ssd_tab[i];
      c = col_tab[i];
      r = row_tab[i];
      j = i;
      while (j > 0 && ssd_tab[j-1] > d) begin
        ssd_tab[j] = ssd_tab[j-1];
        col_tab[j] = col_tab[j-1];
        row_tab[j] = row_tab[j-1];
        j--;
      end
      ssd_tab[j] = d;
      col_tab[j] = c;
      row_tab[j] = r;
    end
    tot = 0;
    for (i = 0; i < n; i++) begin
      tot += fpp_q;
      if (tot > TotalMax) tot = TotalMax;
      stop = (tot >= minp_q) && (ssd_tab[i] > thresh_q);
      m.match_col      = col_tab[i];
      m.match_row      = row_tab[i];
      m.match_distance = ssd_tab[i];
      m.patch_total    = TotalW'(tot);
      m.last_match     = stop || (i + 1 == n);
      match_exp_q.insert(match_exp_q.size(), m);
      if (stop) break;
    end
    cand_cnt = 0;
    ssd_acc  = '0;
  endtask

  function automatic pix_t mk_pix(input int rr, input int rg, input int rb,
                                  input int cr, input int cg, input int cb,
                                  input int col, input int row,
                                  input bit eoc, input bit eow);
    pix_t p;
    p.ref_red          = SampleW'(rr);
    p.ref_green        = SampleW'(rg);
    p.ref_blue         = SampleW'(rb);
    p.cand_red         = SampleW'(cr);
    p.cand_green       = SampleW'(cg);
    p.cand_blue        = SampleW'(cb);
    p.cand_col         = CoordW'(col);
    p.cand_row         = CoordW'(row);
    p.end_of_candidate = eoc;
    p.end_of_window    = eow;
    return p;
  endfunction

  function automatic match_t mk_match(input int col, input int row,
                                      input logic [DistW-1:0] dist_v,
                                      input int tot, input bit last);
    match_t m;
    m.match_col      = CoordW'(col);
    m.match_row      = CoordW'(row);
    m.match_distance = dist_v;
    m.patch_total    = TotalW'(tot);
    m.last_match     = last;
    return m;
  endfunction

  // drive one word from a falling edge, return on the falling edge after
  // acceptance with valid still high
  task automatic send_pair(input pix_t p);
    while ($urandom_range(99) < snd_idle_pct) begin
      pix_bus.valid <= 1'b0;
      pix_bus.data  <= pix_t'(($bits(pix_t))'($urandom()));
      @(negedge clk);
    end
    pix_bus.valid <= 1'b1;
    pix_bus.data  <= p;
    do @(posedge clk); while (!pix_bus.ready);
    predict_pair(p);
    items_sent++;
    @(negedge clk);
  endtask

  // let the block drain completely before touching registers
  task automatic wait_idle();
    pix_bus.valid <= 1'b0;
    while (match_exp_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // three back-to-back register writes, enable lowered once at the end
  task automatic set_regs(input int fpp, input int minp, input logic [31:0] thr);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_FPP;
    cfg_data <= CfgDataW'(fpp);
    @(negedge clk);
    cfg_idx  <= CFG_MINP;
    cfg_data <= CfgDataW'(minp);
    @(negedge clk);
    cfg_idx  <= CFG_THRESH;
    cfg_data <= thr;
    @(negedge clk);
    cfg_we   <= 1'b0;
    fpp_q    = FppW'(fpp);
    minp_q   = TotalW'(minp);
    thresh_q = thr;
  endtask

  // one window of random candidates; near gives small distances and ties
  task automatic send_window(input int ncand, input int maxpix, input bit near);
    int   k;
    int   i;
    int   npix;
    bit   last;
    pix_t p;
    for (k = 0; k < ncand; k++) begin
      npix = $urandom_range(maxpix, 1);
      for (i = 0; i < npix; i++) begin
        last = (k == ncand - 1) && (i == npix - 1);
        p = pix_t'(($bits(pix_t))'({$urandom(), $urandom(), $urandom()}));
        if (near) begin
          p.cand_red   = p.ref_red ^ SampleW'($urandom_range(3));
          p.cand_green = p.ref_green ^ SampleW'($urandom_range(1));
          p.cand_blue  = p.ref_blue ^ SampleW'($urandom_range(3));
        end
        p.end_of_candidate = (i == npix - 1) ? ($urandom_range(4) != 0) : 1'b0;
        // window end may also close the candidate without its own flag
        p.end_of_window = last;
        if (last) p.end_of_candidate = 1'($urandom_range(1));
        send_pair(p);
      end
    end
  endtask

  // receiver: random stalls plus the occasional long hold-off
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt  <= HoldCycles;
      match_bus.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      match_bus.ready <= 1'b0;
    end else begin
      match_bus.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // output checker and watchdog
  always @(posedge clk) begin
    match_t got;
    match_t want;
    if (rst_n) begin
      if ((pix_bus.valid && pix_bus.ready) || (match_bus.valid && match_bus.ready))
        quiet_cnt <= 0;
      else
        quiet_cnt <= quiet_cnt + 1;
      if (quiet_cnt >= WatchLimit) begin
        $display("watchdog: no word moved for %0d cycles", WatchLimit);
        $display("FAILURE");
        $finish;
      end
      if (match_bus.valid && match_bus.ready) begin
        got = match_bus.data;
        if (match_exp_q.size() == 0) begin
          report_mismatch("unexpected match word", '0, got.match_distance);
        end else begin
          want = match_exp_q.pop_front();
          if (got.match_col != want.match_col)
            report_mismatch("match_col", want.match_col, got.match_col);
          if (got.match_row != want.match_row)
            report_mismatch("match_row", want.match_row, got.match_row);
          if (got.match_distance != want.match_distance)
            report_mismatch("match_distance", want.match_distance, got.match_distance);
          if (got.patch_total != want.patch_total)
            report_mismatch("patch_total", want.patch_total, got.patch_total);
          if (got.last_match != want.last_match)
            report_mismatch("last_match", want.last_match, got.last_match);
        end
      end
    end
  end

  initial begin
    int   ph;
    int   start;
    int   i;
    pix_t p;
    errors          = 0;
    items_sent      = 0;
    quiet_cnt       = 0;
    hold_req        = 0;
    hold_seen       = 0;
    hold_cnt        = 0;
    snd_idle_pct    = 0;
    rcv_stall_pct   = 0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_FPP;
    cfg_data        = '0;
    pix_bus.valid   = 1'b0;
    pix_bus.data    = '0;
    match_bus.ready = 1'b0;
    // predictor reset state
    fpp_q    = FppReset;
    minp_q   = MinReset;
    thresh_q = '0;
    ssd_acc  = '0;
    cand_cnt = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed rows, reset register values
    // zero difference, single candidate window
    add_dir_row(mk_pix(0, 0, 0, 0, 0, 0, 0, 0, 1, 1), 1,
                mk_match(0, 0, 0, 5, 1));
    // largest difference, coordinates all ones
    add_dir_row(mk_pix(255, 255, 255, 0, 0, 0, 4095, 4095, 1, 1), 1,
                mk_match(4095, 4095, 195075, 5, 1));
    // window end without candidate end closes the candidate
    add_dir_row(mk_pix(0, 0, 0, 255, 255, 255, 'h123, 'h456, 0, 1), 1,
                mk_match('h123, 'h456, 195075, 5, 1));
    // four candidates with a distance tie, sorted on the window end
    add_dir_row(mk_pix(10, 10, 10, 12, 12, 12, 1, 1, 1, 0), 0, '0);
    add_dir_row(mk_pix(5, 5, 5, 4, 4, 4, 2, 2, 0, 0), 0, '0);
    add_dir_row(mk_pix(7, 8, 9, 7, 8, 9, 2, 2, 1, 0), 0, '0);
    add_dir_row(mk_pix(200, 0, 100, 202, 2, 102, 3, 3, 1, 0), 0, '0);
    add_dir_row(mk_pix(50, 60, 70, 50, 60, 70, 4, 4, 0, 1), 0, '0);
    // multi-pixel candidate with mixed channel differences
    add_dir_row(mk_pix(0, 128, 255, 255, 127, 0, 'hAAA, 'h555, 0, 0), 0, '0);
    add_dir_row(mk_pix(1, 2, 3, 4, 5, 6, 'h555, 'hAAA, 1, 0), 0, '0);
    add_dir_row(mk_pix(128, 128, 128, 127, 129, 128, 'h800, 'h001, 1, 1), 0, '0);
    foreach (dir_tab[i]) begin
      send_pair(dir_tab[i].p);
      if (dir_tab[i].chk) begin
        if (match_exp_q[match_exp_q.size()-1] != dir_tab[i].want)
          report_mismatch("directed row prediction", i, 0);
      end
    end

    for (ph = 0; ph < 8; ph++) begin
      wait_idle();
      case (ph)
        0: set_regs(FppReset, MinReset, '0);
        1: set_regs(1, 1, '0);
        2: set_regs(15, 1023, '1);
        4: set_regs(15, 1, 200);
        7: set_regs(1, 1023, '0);
        default: set_regs($urandom_range(15, 1), $urandom_range(1023, 1),
                          ($urandom_range(1)) ? $urandom_range(300, 0) : $urandom());
      endcase
      case (ph % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 85; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 85; end
        default: begin snd_idle_pct = 7; rcv_stall_pct = 7; end
      endcase
      // long receiver hold-off while windows keep coming, block fills up
      if (ph == 0 || ph == 5) hold_req++;
      // store overflow: more candidates than entries, stop never met
      if (ph == 2) begin
        for (i = 0; i < MaxCand + 2; i++) begin
          p = pix_t'(($bits(pix_t))'({$urandom(), $urandom(), $urandom()}));
          p.end_of_candidate = 1'b1;
          p.end_of_window    = (i == MaxCand + 1);
          send_pair(p);
        end
      end
      start = items_sent;
      while (items_sent - start < PhaseItems) begin
        send_window($urandom_range(8, 1), $urandom_range(5, 1), $urandom_range(1));
      end
    end

    // drain and finish
    wait_idle();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
